// ===== rtl/wns_pkg.sv =====
// Shared types and constants for the Worley nearest-seeds unit.
// Used by the top level and by the iterative multiplier and square root units.
package wns_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COORD_W     = 9;
  localparam int COUNT_W     = 13;
  localparam int DIST_W      = 20;
  localparam int SQ_W        = 24;
  localparam int NOISE_W     = 28;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 80;

  localparam int MUL_W       = 42;
  localparam int MUL_P_W     = 2 * MUL_W;
  localparam int SQ_RAD_W    = 64;
  localparam int SQ_ROOT_W   = SQ_RAD_W / 2;
  localparam int SQ_REM_W    = SQ_ROOT_W + 3;
  localparam int SQ_CNT_W    = $clog2(SQ_ROOT_W);

  localparam logic [SQ_W-1:0] SENTINEL_SQ = 24'd16581375;

  localparam logic [1:0] CFG_SEED_COUNT  = 2'd0;
  localparam logic [1:0] CFG_SEED_OFFSET = 2'd1;
  localparam logic [1:0] CFG_MODE        = 2'd2;

  localparam logic [1:0] MODE_CELL  = 2'd0;
  localparam logic [1:0] MODE_CRACK = 2'd1;
  localparam logic [1:0] MODE_JELLY = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SQ_A,
    ST_SQ_A_W,
    ST_SQ_B,
    ST_SQ_B_W,
    ST_MUL_D,
    ST_MUL_D_W,
    ST_MUL_L,
    ST_MUL_L_W,
    ST_MUL_R,
    ST_MUL_R_W,
    ST_MUL_P,
    ST_MUL_P_W,
    ST_SQ_P,
    ST_SQ_P_W,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/wns_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on wns_pkg for operand widths.
module wns_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wns_pkg::MUL_W-1:0]   a,
  input  logic [wns_pkg::MUL_W-1:0]   b,
  output logic                        busy,
  output logic [wns_pkg::MUL_P_W-1:0] prod
);
  import wns_pkg::*;

  logic [MUL_P_W-1:0] a_sh;
  logic [MUL_W-1:0]   b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy) begin
      busy <= (b_sh >> 1) != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      a_sh <= MUL_P_W'(a);
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// ===== rtl/wns_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on wns_pkg for widths; also reports a nonzero remainder.
module wns_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wns_pkg::SQ_RAD_W-1:0]  rad,
  output logic                          busy,
  output logic [wns_pkg::SQ_ROOT_W-1:0] root,
  output logic                          inexact
);
  import wns_pkg::*;

  logic [SQ_RAD_W-1:0] rad_sh;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;

  assign rem_sh  = {rem[SQ_REM_W-3:0], rad_sh[SQ_RAD_W-1 -: 2]};
  assign trial   = SQ_REM_W'({root, 2'b01});
  assign inexact = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == SQ_CNT_W'(SQ_ROOT_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
      cnt    <= '0;
    end else if (busy) begin
      rad_sh <= rad_sh << 2;
      cnt    <= cnt + 1'b1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/worley_noise_nearest_seeds_unit.sv =====
// Worley noise F1/F2 evaluator over a 1024-word seed table.
// The input is ready again once the result is registered; a table write is taken in the idle
// state without leaving it. The scan reads one table word per cycle; the bit-serial root and
// multiplier then work out the noise value. After reset a clearing pass zeroes all 1024
// table words before any item is taken.
module worley_noise_nearest_seeds_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pixel_x, pixel_y, table_index, table_word, zero fill
  input  logic [wns_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // noise_value, nearest_sq, second_sq, zero fill
  output logic [wns_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [wns_pkg::COUNT_W-1:0]    cfg_data
);
  import wns_pkg::*;

  state_t state, state_next;

  logic [COUNT_W-1:0] seed_count;
  logic [ADDR_W-1:0]  seed_offset;
  logic [1:0]         mode;

  logic [COORD_W-1:0] seed_mem [TABLE_DEPTH];
  logic [COORD_W-1:0] mem_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  clr_addr;

  logic [COORD_W-1:0] px, py;
  logic [COUNT_W:0]   reads_left;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_v, rd_y;
  logic [DIST_W-2:0]  dxsq;
  logic [SQ_W-1:0]    f1, f2;

  logic [20:0]        sa, dval;
  logic [MUL_W-1:0]   dsq;
  logic [MUL_P_W-1:0] lsq;
  logic [NOISE_W-1:0] noise;

  logic               in_acc, is_crack, is_jelly;
  logic signed [COORD_W:0]   dd;
  logic signed [2*COORD_W+1:0] ddsq;
  logic [DIST_W-1:0]  sq_dist;
  logic [SQ_W-1:0]    diff;
  logic signed [MUL_W:0] lv;
  logic               l_pos;
  logic [21:0]        kres;
  logic [SQ_ROOT_W:0] s_ceil;

  logic                 mul_start, mul_busy;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [MUL_P_W-1:0]   mul_prod;
  logic                 sq_start, sq_busy, sq_inexact;
  logic [SQ_RAD_W-1:0]  sq_rad;
  logic [SQ_ROOT_W-1:0] sq_root;

  assign s_axis_tready = state == ST_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign is_crack      = mode == MODE_CRACK;
  assign is_jelly      = mode == MODE_JELLY;

  assign dd   = rd_y ? $signed({1'b0, py}) - $signed({1'b0, mem_q})
                     : $signed({1'b0, px}) - $signed({1'b0, mem_q});
  assign ddsq = dd * dd;
  assign sq_dist = DIST_W'(dxsq) + DIST_W'(ddsq);

  assign diff   = f2 - f1;
  assign lv     = $signed({3'b000, diff, 16'h0000}) - $signed({1'b0, dsq});
  assign l_pos  = !lv[MUL_W] && lv != '0;
  assign kres   = (lsq[MUL_P_W-3:0] <= {mul_prod, 18'h00000}) ? {1'b0, dval}
                                                                : {1'b0, dval} + 22'd1;
  assign s_ceil = {1'b0, sq_root} + (SQ_ROOT_W + 1)'(sq_inexact);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count  <= COUNT_W'(16);
      seed_offset <= '0;
      mode        <= MODE_CELL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEED_COUNT:  seed_count  <= cfg_data;
        CFG_SEED_OFFSET: seed_offset <= cfg_data[ADDR_W-1:0];
        CFG_MODE:        mode        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign mem_we    = state == ST_CLEAR || (in_acc && s_axis_tuser[0] == OP_WRITE);
  assign mem_waddr = state == ST_CLEAR ? clr_addr : s_axis_tdata[27:18];
  assign mem_wdata = state == ST_CLEAR ? '0 : s_axis_tdata[36:28];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seed_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= seed_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    sq_rad     = '0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && s_axis_tuser[0] == OP_EVAL) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (reads_left == '0 && !rd_v) begin
          state_next = is_jelly ? ST_MUL_P : ST_SQ_A;
        end
      end
      ST_SQ_A: begin
        sq_start   = 1'b1;
        sq_rad     = SQ_RAD_W'({f1, 16'h0000});
        state_next = ST_SQ_A_W;
      end
      ST_SQ_A_W: begin
        if (!sq_busy) begin
          state_next = is_crack ? ST_SQ_B : ST_DONE;
        end
      end
      ST_SQ_B: begin
        sq_start   = 1'b1;
        sq_rad     = SQ_RAD_W'({f2, 16'h0000});
        state_next = ST_SQ_B_W;
      end
      ST_SQ_B_W: begin
        if (!sq_busy) begin
          state_next = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        mul_start  = 1'b1;
        mul_a      = MUL_W'(dval);
        mul_b      = MUL_W'(dval);
        state_next = ST_MUL_D_W;
      end
      ST_MUL_D_W: begin
        if (!mul_busy) begin
          state_next = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        if (l_pos) begin
          mul_start  = 1'b1;
          mul_a      = lv[MUL_W-1:0];
          mul_b      = lv[MUL_W-1:0];
          state_next = ST_MUL_L_W;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL_L_W: begin
        if (!mul_busy) begin
          state_next = ST_MUL_R;
        end
      end
      ST_MUL_R: begin
        mul_start  = 1'b1;
        mul_a      = dsq;
        mul_b      = MUL_W'(f1);
        state_next = ST_MUL_R_W;
      end
      ST_MUL_R_W: begin
        if (!mul_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_MUL_P: begin
        mul_start  = 1'b1;
        mul_a      = MUL_W'(f1);
        mul_b      = MUL_W'(f2);
        state_next = ST_MUL_P_W;
      end
      ST_MUL_P_W: begin
        if (!mul_busy) begin
          state_next = ST_SQ_P;
        end
      end
      ST_SQ_P: begin
        sq_start   = 1'b1;
        sq_rad     = {mul_prod[47:0], 16'h0000};
        state_next = ST_SQ_P_W;
      end
      ST_SQ_P_W: begin
        if (!sq_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v       <= 1'b0;
      reads_left <= '0;
    end else begin
      rd_v <= state == ST_SCAN && reads_left != '0;
      if (in_acc && s_axis_tuser[0] == OP_EVAL) begin
        reads_left <= {seed_count, 1'b0};
      end else if (state == ST_SCAN && reads_left != '0) begin
        reads_left <= reads_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_y <= reads_left[0];
    if (in_acc && s_axis_tuser[0] == OP_EVAL) begin
      px      <= s_axis_tdata[8:0];
      py      <= s_axis_tdata[17:9];
      rd_addr <= seed_offset;
      f1      <= SENTINEL_SQ;
      f2      <= SENTINEL_SQ;
    end else if (state == ST_SCAN) begin
      if (reads_left != '0) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (rd_v && !rd_y) begin
        dxsq <= ddsq[DIST_W-2:0];
      end
      if (rd_v && rd_y && SQ_W'(sq_dist) < f2) begin
        if (SQ_W'(sq_dist) < f1) begin
          f2 <= f1;
          f1 <= SQ_W'(sq_dist);
        end else begin
          f2 <= SQ_W'(sq_dist);
        end
      end
    end
    unique case (state)
      ST_SQ_A_W: begin
        sa    <= sq_root[20:0];
        noise <= NOISE_W'(sq_root);
      end
      ST_SQ_B_W: dval <= sq_root[20:0] - sa;
      ST_MUL_D_W: dsq <= mul_prod[MUL_W-1:0];
      ST_MUL_L: noise <= NOISE_W'(0) - NOISE_W'(dval);
      ST_MUL_L_W: lsq <= mul_prod;
      ST_MUL_R_W: begin
        if (!mul_busy) begin
          noise <= NOISE_W'(0) - NOISE_W'(kres);
        end
      end
      ST_SQ_P_W: begin
        if (s_ceil >= (SQ_ROOT_W + 1)'(1 << (NOISE_W - 1))) begin
          noise <= {1'b1, (NOISE_W - 1)'(0)};
        end else begin
          noise <= NOISE_W'(0) - s_ceil[NOISE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {4'h0, f2, f1, noise};
    end
  end

  wns_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  wns_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .rad     (sq_rad),
    .busy    (sq_busy),
    .root    (sq_root),
    .inexact (sq_inexact)
  );

endmodule

// ===== tb/sv/worley_noise_nearest_seeds_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Worley nearest-seeds unit: random table writes and
// pixel evaluations over several register settings, checked by a built-in F1/F2 model.
// Depends on wns_pkg and worley_noise_nearest_seeds_unit.
module worley_noise_nearest_seeds_unit_tb;
  import wns_pkg::*;

  typedef struct {
    logic signed [NOISE_W-1:0] noise;
    logic [SQ_W-1:0]           f1;
    logic [SQ_W-1:0]           f2;
  } noise_result_t;

  class noise_scoreboard;
    logic [COORD_W-1:0] seeds [TABLE_DEPTH];
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  offset;
    logic [1:0]         mode;
    noise_result_t      pending_q [$];
    int                 errors;

    function new();
      foreach (seeds[i]) seeds[i] = '0;
      count = 16;
      offset = 0;
      mode = MODE_CELL;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [COUNT_W-1:0] val);
      case (idx)
        CFG_SEED_COUNT: count = val;
        CFG_SEED_OFFSET: offset = val[ADDR_W-1:0];
        CFG_MODE: mode = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // True when 256*(sqrt(b)-sqrt(a)) <= k.
    function bit crack_ok(logic [63:0] a, logic [63:0] b, logic [63:0] k);
      logic signed [63:0] l;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] m;
      l = $signed((b - a) << 16) - $signed(k * k);
      if (l <= 0) return 1;
      lhs = {64'd0, l} * {64'd0, l};
      m = 128'd512 * k;
      rhs = m * m * {64'd0, a};
      return lhs <= rhs;
    endfunction

    function void note_input(logic op, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                             logic [ADDR_W-1:0] idx, logic [COORD_W-1:0] word);
      logic [63:0] f1;
      logic [63:0] f2;
      logic [63:0] d;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p;
      logic [63:0] s;
      longint dx;
      longint dy;
      longint nv;
      logic [ADDR_W-1:0] ix;
      noise_result_t r;
      if (op == OP_WRITE) begin
        seeds[idx] = word;
        return;
      end
      f1 = SENTINEL_SQ;
      f2 = SENTINEL_SQ;
      for (int i = 0; i < count; i++) begin
        ix = offset + ADDR_W'(2 * i);
        dx = longint'(px) - longint'(seeds[ix]);
        dy = longint'(py) - longint'(seeds[ADDR_W'(ix + 1)]);
        d = dx * dx + dy * dy;
        if (d < f2) begin
          if (d < f1) begin
            f2 = f1;
            f1 = d;
          end else begin
            f2 = d;
          end
        end
      end
      if (mode == MODE_CRACK) begin
        lo = 0;
        hi = 64'd1 << 21;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (crack_ok(f1, f2, mid)) hi = mid;
          else lo = mid + 1;
        end
        nv = -longint'(lo);
      end else if (mode == MODE_JELLY) begin
        p = (f1 * f2) << 16;
        s = root_floor(p);
        if (s * s != p) s++;
        nv = -longint'(s);
        if (nv < -(64'sd1 <<< 27)) nv = -(64'sd1 <<< 27);
      end else begin
        nv = longint'(root_floor(f1 << 16));
      end
      r.noise = nv[NOISE_W-1:0];
      r.f1 = f1[SQ_W-1:0];
      r.f2 = f2[SQ_W-1:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      noise_result_t e;
      logic signed [NOISE_W-1:0] noise;
      logic [SQ_W-1:0] f1;
      logic [SQ_W-1:0] f2;
      noise = data[NOISE_W-1:0];
      f1 = data[NOISE_W +: SQ_W];
      f2 = data[NOISE_W+SQ_W +: SQ_W];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result noise=%0d f1=%0d f2=%0d", $time, noise, f1, f2);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (noise !== e.noise) begin
        $display("%0t: noise_value expected %0d actual %0d", $time, e.noise, noise);
        errors++;
      end
      if (f1 !== e.f1) begin
        $display("%0t: nearest_sq expected %0d actual %0d", $time, e.f1, f1);
        errors++;
      end
      if (f2 !== e.f2) begin
        $display("%0t: second_sq expected %0d actual %0d", $time, e.f2, f2);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;

  int send_idle_pct = 23;
  int recv_idle_pct = 79;
  int stall_cycles = 0;
  noise_scoreboard sb = new();

  worley_noise_nearest_seeds_unit DUT (.*);

  always #2 clk = ~clk;

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain_results();
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [COUNT_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] off, logic [1:0] md);
    drain_results();
    write_reg(CFG_SEED_COUNT, cnt);
    write_reg(CFG_SEED_OFFSET, COUNT_W'(off));
    write_reg(CFG_MODE, COUNT_W'(md));
    cfg_valid <= 0;
  endtask

  task automatic send_item(logic op, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                           logic [ADDR_W-1:0] idx, logic [COORD_W-1:0] word);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, word, idx, py, px};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, px, py, idx, word);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic random_item();
    if ($urandom_range(1)) begin
      send_item(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), ADDR_W'($urandom),
                COORD_W'($urandom));
    end else begin
      send_item(OP_EVAL, COORD_W'($urandom), COORD_W'($urandom), ADDR_W'($urandom),
                COORD_W'($urandom));
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] cnt;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Empty table: every seed sits at the origin.
    send_item(OP_EVAL, 0, 0, 0, 0);
    send_item(OP_WRITE, 0, 0, 0, 511);
    send_item(OP_WRITE, 0, 0, 1, 0);
    send_item(OP_WRITE, 0, 0, 1023, 511);
    send_item(OP_WRITE, 0, 0, 2, 255);
    send_item(OP_WRITE, 0, 0, 3, 256);
    send_item(OP_WRITE, 0, 0, 4, 511);
    send_item(OP_WRITE, 0, 0, 5, 0);
    send_item(OP_EVAL, 511, 511, 0, 0);
    // No seeds: both distances keep the sentinel.
    apply_setting(0, 0, MODE_CRACK);
    send_item(OP_EVAL, 511, 511, 0, 0);
    // One seed that wraps around the table end; jelly saturates.
    apply_setting(1, 1023, MODE_JELLY);
    send_item(OP_EVAL, 0, 511, 0, 0);
    apply_setting(2, 0, MODE_CRACK);
    send_item(OP_EVAL, 100, 200, 0, 0);
    apply_setting(2, 0, MODE_JELLY);
    send_item(OP_EVAL, 300, 17, 0, 0);
    // Equal distances do not replace; the unused mode acts as cell.
    apply_setting(3, 0, 2'd3);
    send_item(OP_EVAL, 0, 0, 0, 0);
    apply_setting(4096, 0, MODE_CELL);
    send_item(OP_EVAL, 511, 0, 0, 0);
    send_item(OP_EVAL, 7, 400, 0, 0);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 23;
        recv_idle_pct = 79;
      end else if (ph < 8) begin
        send_idle_pct = 79;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cnt = (ph % 5 == 4) ? COUNT_W'($urandom_range(0, 1)) : COUNT_W'($urandom_range(2, 40));
      apply_setting(cnt, ADDR_W'($urandom), 2'(ph % 4));
      for (int i = 0; i < 130; i++) random_item();
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
